@@ hdl/assert_macros.svh @@
// Assertion helpers used by the RTL top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_SAME_CYCLE(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT_CYCLE(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_SAME_CYCLE(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT_CYCLE(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/rrc_pkg.sv @@
`timescale 1ns / 1ps
package rrc_pkg;

    localparam int unsigned AddrW  = 5;
    localparam int unsigned SDataW = 8;
    localparam int unsigned MDataW = 16;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_DEV_CHG = 2'd1,
        FUNC_START   = 2'd2,
        FUNC_STOP    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_FAST_DELAY    = 3'd0,
        REG_SLOW_DELAY    = 3'd1,
        REG_FAST_ATTEMPTS = 3'd2,
        REG_MAX_ATTEMPTS  = 3'd3,
        REG_HEALTHY_TICKS = 3'd4,
        REG_STATUS_EVERY  = 3'd5,
        REG_HEALTH_EVERY  = 3'd6,
        REG_REARM_DELAY   = 3'd7
    } reg_idx_t;

    localparam logic [9:0]  FAST_DELAY_RST    = 10'd12;
    localparam logic [9:0]  SLOW_DELAY_RST    = 10'd100;
    localparam logic [5:0]  FAST_ATTEMPTS_RST = 6'd10;
    localparam logic [5:0]  MAX_ATTEMPTS_RST  = 6'd34;
    localparam logic [15:0] HEALTHY_TICKS_RST = 16'd100;
    localparam logic [7:0]  STATUS_EVERY_RST  = 8'd10;
    localparam logic [15:0] HEALTH_EVERY_RST  = 16'd12000;
    localparam logic [9:0]  REARM_DELAY_RST   = 10'd2;

    localparam logic [5:0]  ATTEMPTS_MAX = 6'd63;
    localparam logic [15:0] TSS_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [9:0]  fast_delay;
        logic [9:0]  slow_delay;
        logic [5:0]  fast_attempts;
        logic [5:0]  max_attempts;
        logic [15:0] healthy_ticks;
        logic [7:0]  status_every;
        logic [15:0] health_every;
        logic [9:0]  rearm_delay;
    } cfg_t;

    typedef struct packed {
        logic        recovering_flag;
        logic        user_wants_run;
        logic        seen_running;
        logic [5:0]  attempts;
        logic [9:0]  retry_countdown;
        logic [15:0] ticks_since_start;
        logic [7:0]  ticks_since_status;
        logic [15:0] ticks_since_health;
    } state_t;

    typedef struct packed {
        func_t func;
        logic  engine_running;
        logic  fault_seen;
        logic  start_ok;
    } item_t;

    // packed high to low so that recovering lands in bit 0 of tdata
    typedef struct packed {
        logic [5:0] attempt_count;
        logic       health_report;
        logic       publish_status;
        logic       gave_up;
        logic       stop_engine;
        logic       try_start;
        logic       recovering;
    } result_t;

endpackage

@@ hdl/rrc_cfg.sv @@
`timescale 1ns / 1ps
module rrc_cfg
    import rrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [AddrW-1:0]   paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_FAST_DELAY:    cfg_next.fast_delay    = pwdata[9:0];
                REG_SLOW_DELAY:    cfg_next.slow_delay    = pwdata[9:0];
                REG_FAST_ATTEMPTS: cfg_next.fast_attempts = pwdata[5:0];
                REG_MAX_ATTEMPTS:  cfg_next.max_attempts  = pwdata[5:0];
                REG_HEALTHY_TICKS: cfg_next.healthy_ticks = pwdata[15:0];
                REG_STATUS_EVERY:  cfg_next.status_every  = pwdata[7:0];
                REG_HEALTH_EVERY:  cfg_next.health_every  = pwdata[15:0];
                REG_REARM_DELAY:   cfg_next.rearm_delay   = pwdata[9:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FAST_DELAY:    prdata = {22'd0, cfg_reg.fast_delay};
            REG_SLOW_DELAY:    prdata = {22'd0, cfg_reg.slow_delay};
            REG_FAST_ATTEMPTS: prdata = {26'd0, cfg_reg.fast_attempts};
            REG_MAX_ATTEMPTS:  prdata = {26'd0, cfg_reg.max_attempts};
            REG_HEALTHY_TICKS: prdata = {16'd0, cfg_reg.healthy_ticks};
            REG_STATUS_EVERY:  prdata = {24'd0, cfg_reg.status_every};
            REG_HEALTH_EVERY:  prdata = {16'd0, cfg_reg.health_every};
            REG_REARM_DELAY:   prdata = {22'd0, cfg_reg.rearm_delay};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_delay    <= FAST_DELAY_RST;
            cfg_reg.slow_delay    <= SLOW_DELAY_RST;
            cfg_reg.fast_attempts <= FAST_ATTEMPTS_RST;
            cfg_reg.max_attempts  <= MAX_ATTEMPTS_RST;
            cfg_reg.healthy_ticks <= HEALTHY_TICKS_RST;
            cfg_reg.status_every  <= STATUS_EVERY_RST;
            cfg_reg.health_every  <= HEALTH_EVERY_RST;
            cfg_reg.rearm_delay   <= REARM_DELAY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/rrc_step.sv @@
`timescale 1ns / 1ps
module rrc_step
    import rrc_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  st,
    input  item_t   item,
    output state_t  st_next,
    output result_t res
);

    logic       run;
    logic [5:0] att_inc;
    logic [15:0] tsh_inc;
    logic [7:0]  tst_inc;

    assign run     = item.engine_running;
    assign att_inc = (st.attempts < ATTEMPTS_MAX) ? st.attempts + 6'd1 : st.attempts;
    assign tsh_inc = st.ticks_since_health + 16'd1;
    assign tst_inc = st.ticks_since_status + 8'd1;

    always_comb begin
        st_next = st;
        res     = '0;
        unique case (item.func)
            FUNC_TICK: begin
                if (item.fault_seen) begin
                    res.stop_engine         = 1'b1;
                    res.publish_status      = 1'b1;
                    st_next.seen_running    = 1'b0;
                    st_next.recovering_flag = 1'b1;
                    if (st.ticks_since_start >= cfg.healthy_ticks) begin
                        st_next.attempts = '0;
                    end
                    st_next.ticks_since_start = '0;
                    st_next.retry_countdown   = cfg.fast_delay;
                end else if (st.recovering_flag) begin
                    if (st.retry_countdown > 10'd1) begin
                        st_next.retry_countdown = st.retry_countdown - 10'd1;
                    end else begin
                        st_next.retry_countdown = (st.attempts < cfg.fast_attempts)
                                                  ? cfg.fast_delay : cfg.slow_delay;
                        res.try_start = 1'b1;
                        if (item.start_ok) begin
                            st_next.seen_running      = 1'b1;
                            st_next.recovering_flag   = 1'b0;
                            st_next.ticks_since_start = '0;
                            st_next.attempts          = '0;
                            res.publish_status        = 1'b1;
                        end else begin
                            st_next.attempts = att_inc;
                            if (att_inc >= cfg.max_attempts) begin
                                st_next.recovering_flag = 1'b0;
                                res.gave_up             = 1'b1;
                                res.publish_status      = 1'b1;
                            end
                        end
                    end
                end else begin
                    if (run) begin
                        if (st.ticks_since_start < TSS_MAX) begin
                            st_next.ticks_since_start = st.ticks_since_start + 16'd1;
                        end
                        if (tsh_inc >= cfg.health_every) begin
                            st_next.ticks_since_health = '0;
                            res.health_report          = 1'b1;
                        end else begin
                            st_next.ticks_since_health = tsh_inc;
                        end
                    end
                    if (run != st.seen_running) begin
                        st_next.seen_running       = run;
                        st_next.ticks_since_status = '0;
                        res.publish_status         = 1'b1;
                    end else if (run) begin
                        if (tst_inc >= cfg.status_every) begin
                            st_next.ticks_since_status = '0;
                            res.publish_status         = 1'b1;
                        end else begin
                            st_next.ticks_since_status = tst_inc;
                        end
                    end
                end
            end
            FUNC_DEV_CHG: begin
                if (st.recovering_flag) begin
                    st_next.retry_countdown = cfg.rearm_delay;
                end else if (st.user_wants_run && !run) begin
                    st_next.recovering_flag = 1'b1;
                    st_next.attempts        = '0;
                    st_next.retry_countdown = cfg.rearm_delay;
                    res.publish_status      = 1'b1;
                end
            end
            FUNC_START: begin
                if (!run) begin
                    res.publish_status = 1'b1;
                    if (item.start_ok) begin
                        st_next.seen_running      = 1'b1;
                        st_next.user_wants_run    = 1'b1;
                        st_next.recovering_flag   = 1'b0;
                        st_next.attempts          = '0;
                        st_next.ticks_since_start = '0;
                    end
                end
            end
            FUNC_STOP: begin
                st_next.user_wants_run  = 1'b0;
                st_next.recovering_flag = 1'b0;
                st_next.attempts        = '0;
                if (run) begin
                    res.stop_engine      = 1'b1;
                    res.publish_status   = 1'b1;
                    st_next.seen_running = 1'b0;
                end
            end
            default: st_next = st;
        endcase
        res.recovering    = st_next.recovering_flag;
        res.attempt_count = st_next.attempts;
    end

endmodule

@@ hdl/reconnect_retry_controller_top.sv @@
`timescale 1ns / 1ps
// Each accepted input beat gives a registered result beat on m_ in the cycle after
// the accept. Throughput: one beat per cycle while m_ is not stalled by m_tready;
// the state update and the result register are both loaded in the accept cycle, so
// back-to-back events see fresh state. Reset (aresetn low, synchronous): state
// cleared, registers at default values, no result pending.
module reconnect_retry_controller_top
    import rrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SDataW-1:0]  s_tdata,  // engine_running, fault_seen, start_ok, zero pad
    input  logic [1:0]         s_tuser,  // func
    output logic               m_tvalid,
    input  logic               m_tready,
    // recovering, try_start, stop_engine, gave_up, publish_status,
    // health_report, attempt_count[5:0], zero pad
    output logic [MDataW-1:0]  m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [AddrW-1:0]   paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "assert_macros.svh"

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item;
    result_t res_next;
    result_t res_reg;
    logic    m_valid_reg;
    logic    accept;

    rrc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item.func           = func_t'(s_tuser);
    assign item.engine_running = s_tdata[0];
    assign item.fault_seen     = s_tdata[1];
    assign item.start_ok       = s_tdata[2];

    rrc_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .item    (item),
        .st_next (state_next),
        .res     (res_next)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(MDataW - $bits(result_t)){1'b0}}, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    `ASSERT_NEXT_CYCLE(a_accept_gives_beat, aclk, aresetn, accept, m_valid_reg)
    `ASSERT_SAME_CYCLE(a_gave_up_ends_recovery, aclk, aresetn,
        m_valid_reg && res_reg.gave_up, !res_reg.recovering)
    `ASSERT_SAME_CYCLE(a_try_not_stop, aclk, aresetn,
        m_valid_reg, !(res_reg.try_start && res_reg.stop_engine))
    `ASSERT_NEXT_CYCLE(a_result_tracks_state, aclk, aresetn,
        accept, res_reg.recovering == state_reg.recovering_flag)

endmodule

@@ bench/reconnect_retry_controller_checker.sv @@
`timescale 1ns / 1ps
module reconnect_retry_controller_checker
    import rrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [SDataW-1:0]  s_tdata,  // engine_running, fault_seen, start_ok, zero pad
    input  logic [1:0]         s_tuser,  // func
    input  logic               m_tvalid,
    input  logic               m_tready,
    // recovering, try_start, stop_engine, gave_up, publish_status,
    // health_report, attempt_count[5:0], zero pad
    input  logic [MDataW-1:0]  m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [AddrW-1:0]   paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 mismatches,
    output int                 pending,
    output int                 events_seen,
    output int                 attempts_seen,
    output int                 give_ups_seen,
    output int                 health_seen
);

    logic [9:0]  cf_fast, cf_slow, cf_rearm;
    logic [5:0]  cf_fast_n, cf_max_n;
    logic [15:0] cf_healthy, cf_health;
    logic [7:0]  cf_status;

    logic        rec, wants_run, saw_run;
    logic [5:0]  n_fail;
    logic [9:0]  countdown;
    logic [15:0] up_ticks, health_ticks;
    logic [7:0]  status_ticks;

    result_t due_results [$];

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    task automatic step_supervisor(input func_t fn, input logic run, input logic flt,
                                   input logic ok, output result_t r);
        r = '0;
        case (fn)
            FUNC_TICK: begin
                if (flt) begin
                    r.stop_engine = 1'b1;
                    r.publish_status = 1'b1;
                    saw_run = 1'b0;
                    rec = 1'b1;
                    if (up_ticks >= cf_healthy)
                        n_fail = '0;
                    up_ticks = '0;
                    countdown = cf_fast;
                end else if (rec) begin
                    if (countdown > 10'd1) begin
                        countdown--;
                    end else begin
                        countdown = (n_fail < cf_fast_n) ? cf_fast : cf_slow;
                        r.try_start = 1'b1;
                        if (ok) begin
                            saw_run = 1'b1;
                            rec = 1'b0;
                            up_ticks = '0;
                            n_fail = '0;
                            r.publish_status = 1'b1;
                        end else begin
                            if (n_fail != ATTEMPTS_MAX)
                                n_fail++;
                            if (n_fail >= cf_max_n) begin
                                rec = 1'b0;
                                r.gave_up = 1'b1;
                                r.publish_status = 1'b1;
                            end
                        end
                    end
                end else begin
                    if (run) begin
                        if (up_ticks != TSS_MAX)
                            up_ticks++;
                        health_ticks++;
                        if (health_ticks >= cf_health) begin
                            health_ticks = '0;
                            r.health_report = 1'b1;
                        end
                    end
                    if (run != saw_run) begin
                        saw_run = run;
                        status_ticks = '0;
                        r.publish_status = 1'b1;
                    end else if (run) begin
                        status_ticks++;
                        if (status_ticks >= cf_status) begin
                            status_ticks = '0;
                            r.publish_status = 1'b1;
                        end
                    end
                end
            end
            FUNC_DEV_CHG: begin
                if (rec) begin
                    countdown = cf_rearm;
                end else if (wants_run && !run) begin
                    rec = 1'b1;
                    n_fail = '0;
                    countdown = cf_rearm;
                    r.publish_status = 1'b1;
                end
            end
            FUNC_START: begin
                if (!run) begin
                    r.publish_status = 1'b1;
                    if (ok) begin
                        saw_run = 1'b1;
                        wants_run = 1'b1;
                        rec = 1'b0;
                        n_fail = '0;
                        up_ticks = '0;
                    end
                end
            end
            FUNC_STOP: begin
                wants_run = 1'b0;
                rec = 1'b0;
                n_fail = '0;
                if (run) begin
                    r.stop_engine = 1'b1;
                    r.publish_status = 1'b1;
                    saw_run = 1'b0;
                end
            end
            default: ;
        endcase
        r.recovering = rec;
        r.attempt_count = n_fail;
    endtask

    always @(posedge aclk) begin : watch
        result_t    want, got;
        logic [31:0] reg_now;
        if (!aresetn) begin
            cf_fast = FAST_DELAY_RST;
            cf_slow = SLOW_DELAY_RST;
            cf_fast_n = FAST_ATTEMPTS_RST;
            cf_max_n = MAX_ATTEMPTS_RST;
            cf_healthy = HEALTHY_TICKS_RST;
            cf_status = STATUS_EVERY_RST;
            cf_health = HEALTH_EVERY_RST;
            cf_rearm = REARM_DELAY_RST;
            rec = 1'b0;
            wants_run = 1'b0;
            saw_run = 1'b0;
            n_fail = '0;
            countdown = '0;
            up_ticks = '0;
            health_ticks = '0;
            status_ticks = '0;
            due_results.delete();
            pending = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (reg_idx_t'(paddr[4:2]))
                        REG_FAST_DELAY:    cf_fast = pwdata[9:0];
                        REG_SLOW_DELAY:    cf_slow = pwdata[9:0];
                        REG_FAST_ATTEMPTS: cf_fast_n = pwdata[5:0];
                        REG_MAX_ATTEMPTS:  cf_max_n = pwdata[5:0];
                        REG_HEALTHY_TICKS: cf_healthy = pwdata[15:0];
                        REG_STATUS_EVERY:  cf_status = pwdata[7:0];
                        REG_HEALTH_EVERY:  cf_health = pwdata[15:0];
                        REG_REARM_DELAY:   cf_rearm = pwdata[9:0];
                        default: ;
                    endcase
                end else begin
                    case (reg_idx_t'(paddr[4:2]))
                        REG_FAST_DELAY:    reg_now = 32'(cf_fast);
                        REG_SLOW_DELAY:    reg_now = 32'(cf_slow);
                        REG_FAST_ATTEMPTS: reg_now = 32'(cf_fast_n);
                        REG_MAX_ATTEMPTS:  reg_now = 32'(cf_max_n);
                        REG_HEALTHY_TICKS: reg_now = 32'(cf_healthy);
                        REG_STATUS_EVERY:  reg_now = 32'(cf_status);
                        REG_HEALTH_EVERY:  reg_now = 32'(cf_health);
                        default:           reg_now = 32'(cf_rearm);
                    endcase
                    if (prdata !== reg_now)
                        note_mismatch($sformatf("register read at 0x%h", paddr), reg_now, prdata);
                end
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (due_results.size() == 0) begin
                    note_mismatch("result beat with nothing outstanding", '0, 32'(got));
                end else begin
                    want = due_results.pop_front();
                    if (got !== want)
                        note_mismatch("result beat", 32'(want), 32'(got));
                end
            end
            if (s_tvalid && s_tready) begin
                step_supervisor(func_t'(s_tuser), s_tdata[0], s_tdata[1], s_tdata[2], want);
                due_results = {due_results, want};
                events_seen++;
                if (want.try_start)
                    attempts_seen++;
                if (want.gave_up)
                    give_ups_seen++;
                if (want.health_report)
                    health_seen++;
            end
            pending = due_results.size();
        end
    end

endmodule

@@ bench/reconnect_retry_controller_top_tb.sv @@
`timescale 1ns / 1ps
module reconnect_retry_controller_top_tb;
    import rrc_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int NumPhases  = 10;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [SDataW-1:0]  s_tdata = '0;   // engine_running, fault_seen, start_ok, zero pad
    logic [1:0]         s_tuser = '0;   // func
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // recovering, try_start, stop_engine, gave_up, publish_status,
    // health_report, attempt_count[5:0], zero pad
    logic [MDataW-1:0]  m_tdata;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [AddrW-1:0]   paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int mismatches, pending, events_seen, attempts_seen, give_ups_seen, health_seen;
    int cycles = 0;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int ok_pct, flt_pct, ev_pct, n_rand;
    bit eng_up = 1'b0;
    logic [31:0] settings [8];

    always #5 aclk = ~aclk;

    reconnect_retry_controller_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    reconnect_retry_controller_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .pending       (pending),
        .events_seen   (events_seen),
        .attempts_seen (attempts_seen),
        .give_ups_seen (give_ups_seen),
        .health_seen   (health_seen)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("reconnect_retry_controller_top_tb: errors");
            $finish;
        end
    end

    // result side back-pressure: free-flowing, coin flip, sparse, periodic
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (cycles[2:0] == 3'd0);
        endcase
    end

    task automatic send_beat(func_t fn, bit run, bit flt, bit ok);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= SDataW'({ok, flt, run});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic pick_event(output func_t fn, output bit run, output bit flt, output bit ok);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            fn = func_t'($urandom_range(0, 3));
            run = $urandom_range(0, 1);
            flt = $urandom_range(0, 1);
            ok = $urandom_range(0, 1);
        end else begin
            if ($urandom_range(0, 99) < ev_pct) begin
                roll = $urandom_range(0, 99);
                fn = (roll < 45) ? FUNC_DEV_CHG : (roll < 85) ? FUNC_START : FUNC_STOP;
            end else begin
                fn = FUNC_TICK;
            end
            run = ($urandom_range(0, 99) < 90) ? eng_up : !eng_up;
            flt = (fn == FUNC_TICK) ? ($urandom_range(0, 99) < flt_pct) : $urandom_range(0, 1);
            ok = ($urandom_range(0, 99) < ok_pct);
        end
        case (fn)
            FUNC_TICK: begin
                if (flt)
                    eng_up = 1'b0;
                else if (ok && !eng_up && $urandom_range(0, 3) == 0)
                    eng_up = 1'b1;
            end
            FUNC_START: if (ok) eng_up = 1'b1;
            FUNC_STOP:  eng_up = 1'b0;
            default: ;
        endcase
    endtask

    task automatic apb_access(bit wr, reg_idx_t idx, logic [31:0] wdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic apb_sweep(bit load);
        if (load)
            for (int i = 0; i < 8; i++)
                apb_access(1'b1, reg_idx_t'(i), settings[i]);
        for (int i = 0; i < 8; i++)
            apb_access(1'b0, reg_idx_t'(i), '0);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic plan_settings(int fast, int slow, int fast_n, int max_n,
                                 int healthy, int status, int health, int rearm);
        settings[REG_FAST_DELAY]    = fast;
        settings[REG_SLOW_DELAY]    = slow;
        settings[REG_FAST_ATTEMPTS] = fast_n;
        settings[REG_MAX_ATTEMPTS]  = max_n;
        settings[REG_HEALTHY_TICKS] = healthy;
        settings[REG_STATUS_EVERY]  = status;
        settings[REG_HEALTH_EVERY]  = health;
        settings[REG_REARM_DELAY]   = rearm;
    endtask

    task automatic settle();
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        func_t fn;
        bit    run, flt, ok;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        apb_sweep(1'b0);
        for (int ph = 0; ph < NumPhases; ph++) begin
            ok_pct = 35;
            flt_pct = 6;
            ev_pct = 25;
            n_rand = 70;
            case (ph)
                0: n_rand = 60;
                1: begin
                    plan_settings(0, 0, 0, 0, 0, 0, 0, 0);
                    n_rand = 50;
                end
                2: begin
                    plan_settings(1, 1, 0, 1, 1, 1, 1, 1);
                    n_rand = 90;
                end
                3: begin
                    plan_settings(1023, 1023, 63, 63, 65535, 255, 65535, 1023);
                    n_rand = 60;
                end
                4: begin
                    // long failing recovery, drives the attempt count to saturation
                    plan_settings(1, 1, 2, 63, 65535, 3, 5, 1);
                    ok_pct = 1;
                    flt_pct = 2;
                    ev_pct = 3;
                    n_rand = 150;
                end
                default: begin
                    plan_settings($urandom_range(1, 5), $urandom_range(1, 8),
                                  $urandom_range(0, 4), $urandom_range(1, 8),
                                  $urandom_range(1, 30), $urandom_range(1, 6),
                                  $urandom_range(1, 20), $urandom_range(1, 4));
                end
            endcase
            if (ph != 0) begin
                s_tvalid <= 1'b0;
                settle();
                apb_sweep(1'b1);
            end
            if (ph == 0) begin
                send_beat(FUNC_TICK,    1'b0, 1'b0, 1'b0);
                send_beat(FUNC_START,   1'b0, 1'b0, 1'b0);
                send_beat(FUNC_START,   1'b0, 1'b0, 1'b1);
                send_beat(FUNC_START,   1'b1, 1'b1, 1'b1);  // start while running
                send_beat(FUNC_TICK,    1'b1, 1'b0, 1'b0);
                send_beat(FUNC_TICK,    1'b1, 1'b1, 1'b1);  // fault, running/ok ignored
                send_beat(FUNC_TICK,    1'b0, 1'b0, 1'b0);
                send_beat(FUNC_DEV_CHG, 1'b0, 1'b0, 1'b0);
                send_beat(FUNC_TICK,    1'b0, 1'b0, 1'b0);
                send_beat(FUNC_TICK,    1'b0, 1'b0, 1'b0);
                send_beat(FUNC_DEV_CHG, 1'b0, 1'b1, 1'b1);
                send_beat(FUNC_TICK,    1'b0, 1'b0, 1'b0);
                send_beat(FUNC_TICK,    1'b0, 1'b0, 1'b1);
                send_beat(FUNC_TICK,    1'b1, 1'b0, 1'b0);
                send_beat(FUNC_STOP,    1'b1, 1'b0, 1'b0);
                send_beat(FUNC_DEV_CHG, 1'b0, 1'b0, 1'b0);
                send_beat(FUNC_START,   1'b0, 1'b0, 1'b1);
                send_beat(FUNC_TICK,    1'b1, 1'b1, 1'b0);
                send_beat(FUNC_STOP,    1'b0, 1'b1, 1'b1);
                send_beat(FUNC_TICK,    1'b1, 1'b0, 1'b0);  // running without a start
            end
            if (ph == 1) begin
                send_beat(FUNC_START,   1'b0, 1'b0, 1'b1);
                send_beat(FUNC_TICK,    1'b1, 1'b0, 1'b0);
                send_beat(FUNC_TICK,    1'b1, 1'b0, 1'b0);
                send_beat(FUNC_TICK,    1'b1, 1'b1, 1'b0);
                send_beat(FUNC_TICK,    1'b0, 1'b0, 1'b0);  // zero countdown, zero budget
                send_beat(FUNC_DEV_CHG, 1'b0, 1'b0, 1'b0);  // re-arm after give-up
                send_beat(FUNC_TICK,    1'b0, 1'b0, 1'b1);
                send_beat(FUNC_TICK,    1'b1, 1'b0, 1'b0);
                send_beat(FUNC_DEV_CHG, 1'b1, 1'b0, 1'b0);
                send_beat(FUNC_STOP,    1'b1, 1'b0, 1'b0);
            end
            repeat (n_rand) begin
                pick_event(fn, run, flt, ok);
                send_beat(fn, run, flt, ok);
            end
        end
        s_tvalid <= 1'b0;
        settle();
        $display("%0d events checked across %0d register settings", events_seen, NumPhases);
        $display("%0d reconnect attempts, %0d give-ups, %0d health pulses",
                 attempts_seen, give_ups_seen, health_seen);
        if (mismatches == 0)
            $display("reconnect_retry_controller_top_tb: clean");
        else
            $display("reconnect_retry_controller_top_tb: errors");
        $finish;
    end

endmodule
